### rtl/lits_pkg.sv
// Shared types and constants for the 9-bit serial LCD init sequencer.
// Used by lits_front, lits_queue, lits_back and the top level.
package lits_pkg;

  localparam logic [7:0] MARK_DELAY = 8'hFE;
  localparam logic [7:0] MARK_END   = 8'hFF;
  localparam logic [3:0] LAST_BIT   = 4'd8;

  localparam logic [1:0] KIND_BIT   = 2'd0;
  localparam logic [1:0] KIND_DELAY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       flag;
    logic [7:0] value;
  } op_t;

endpackage

### rtl/lits_front.sv
// Table parser: classifies each accepted byte and issues one operation or none.
// Depends on lits_pkg.
module lits_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     table_byte,
  output logic           op_valid,
  output lits_pkg::op_t  op
);

  typedef enum logic [2:0] {
    PH_CMD, PH_SECOND, PH_DELAY, PH_DATA, PH_PAD, PH_DONE
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] remain_r, remain_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    remain_nxt = remain_r;
    op_valid   = 1'b0;
    op.kind    = lits_pkg::KIND_BIT;
    op.flag    = 1'b0;
    op.value   = table_byte;
    case (phase_r)
      PH_SECOND: begin
        if (table_byte == lits_pkg::MARK_END) begin
          op_valid  = 1'b1;
          op.kind   = lits_pkg::KIND_END;
          op.value  = 8'd0;
          phase_nxt = PH_DONE;
        end else if (table_byte == lits_pkg::MARK_DELAY) begin
          phase_nxt = PH_DELAY;
        end else begin
          op_valid = 1'b1;
          op.value = held_r;
          if (table_byte == 8'd0) begin
            phase_nxt = PH_PAD;
          end else begin
            remain_nxt = table_byte;
            phase_nxt  = PH_DATA;
          end
        end
      end
      PH_DELAY: begin
        op_valid  = 1'b1;
        op.kind   = lits_pkg::KIND_DELAY;
        phase_nxt = PH_CMD;
      end
      PH_DATA: begin
        op_valid   = 1'b1;
        op.flag    = 1'b1;
        remain_nxt = remain_r - 8'd1;
        if (remain_nxt == 8'd0) begin
          phase_nxt = PH_CMD;
        end
      end
      PH_PAD: begin
        phase_nxt = PH_CMD;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        held_nxt  = table_byte;
        phase_nxt = PH_SECOND;
      end
    endcase
    op_valid = op_valid & accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CMD;
      held_r   <= 8'd0;
      remain_r <= 8'd0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      remain_r <= remain_nxt;
    end
  end

endmodule

### rtl/lits_queue.sv
// Short operation queue between parser and serialiser.
// Depends on lits_pkg.
module lits_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  lits_pkg::op_t  wr_op,
  input  logic           rd_en,
  output lits_pkg::op_t  rd_op,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_TOP = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_TOP = CW'(DEPTH);

  lits_pkg::op_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign full  = (count_r == CNT_TOP);
  assign empty = (count_r == '0);
  assign do_wr = wr_en & ~full;
  assign do_rd = rd_en & ~empty;
  assign rd_op = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_TOP) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_TOP) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

### rtl/lits_back.sv
// Serialiser: turns queued operations into bit, delay and end results.
// Depends on lits_pkg.
module lits_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lits_pkg::op_t  q_op,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     kind,
  output logic           serial_bit,
  output logic [7:0]     delay_ms,
  output logic           last
);

  logic       busy_r;
  logic [1:0] kind_r;
  logic [8:0] shift_r;
  logic [3:0] cnt_r;
  logic [7:0] delay_r;
  logic       take, finish, load;

  assign empty      = ~busy_r;
  assign kind       = kind_r;
  assign serial_bit = (kind_r == lits_pkg::KIND_BIT) & shift_r[8];
  assign delay_ms   = delay_r;
  assign last       = (kind_r != lits_pkg::KIND_BIT) | (cnt_r == lits_pkg::LAST_BIT);

  assign take   = busy_r & pop;
  assign finish = take & last;
  assign load   = (~busy_r | finish) & ~q_empty;
  assign q_pop  = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (finish) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= q_op.kind;
      shift_r <= {q_op.flag, q_op.value};
      cnt_r   <= 4'd0;
      delay_r <= (q_op.kind == lits_pkg::KIND_DELAY) ? q_op.value : 8'd0;
    end else if (take) begin
      shift_r <= {shift_r[7:0], 1'b0};
      cnt_r   <= cnt_r + 4'd1;
    end
  end

endmodule

### rtl/lcd_init_table_spi9_sequencer.sv
// Top level of the 9-bit serial LCD init sequencer.
// Instantiates lits_front, lits_queue and lits_back; uses lits_pkg.
//
// Usage: push table bytes on in_table_byte with in_push while in_full is low.
// Results come out as a queue: while out_empty is low, out_kind, out_serial_bit,
// out_delay_ms and out_last show the oldest result; pulse out_pop to take it.
// Kind 0 is one serial bit (nine per word, flag bit first, out_last on the
// ninth), kind 1 a delay request, kind 2 the table end (out_last always set).
// A byte's first result is written to the operation queue, then loaded into the serialiser.
// Throughput: the parser takes one byte per cycle while the operation queue
// has room; the serialiser emits one bit per cycle while the receiver pops,
// so a command or data byte gives nine bit results, a delay or end record one.
// A stalled receiver holds the serialiser; the queue (QUEUE_DEPTH operations)
// then fills and in_full rises. Bytes that give no result are always taken
// while the queue is not full.
// Reset clears the parser to expect a command byte, empties the queue and
// the serialiser; after the table end, later bytes are taken and dropped.
module lcd_init_table_spi9_sequencer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_table_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_kind,
  output logic       out_serial_bit,
  output logic [7:0] out_delay_ms,
  output logic       out_last
);

  logic          accept;
  logic          op_valid;
  lits_pkg::op_t op;
  lits_pkg::op_t q_op;
  logic          q_pop, q_empty, q_full;

  assign in_full = q_full;
  assign accept  = in_push & ~q_full;

  lits_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .table_byte (in_table_byte),
    .op_valid   (op_valid),
    .op         (op)
  );

  lits_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (op_valid),
    .wr_op (op),
    .rd_en (q_pop),
    .rd_op (q_op),
    .full  (q_full),
    .empty (q_empty)
  );

  lits_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_op       (q_op),
    .q_pop      (q_pop),
    .pop        (out_pop),
    .empty      (out_empty),
    .kind       (out_kind),
    .serial_bit (out_serial_bit),
    .delay_ms   (out_delay_ms),
    .last       (out_last)
  );

endmodule

### bench/tb_lcd_init_table_spi9_sequencer.sv
`timescale 1ns / 1ps
// Testbench for lcd_init_table_spi9_sequencer: drives init table streams and checks
// every serial bit, delay request and table end against an in-bench predictor.
// Depends on lits_pkg and the sequencer RTL only.
module tb_lcd_init_table_spi9_sequencer;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_BYTES = 32;
  localparam int SETTLE       = 12;

  typedef enum logic [2:0] {
    ST_COMMAND, ST_SECOND, ST_DELAY, ST_DATA, ST_PAD, ST_ENDED
  } table_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       serial_bit;
    logic [7:0] delay_ms;
    logic       last;
  } lcd_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_table_byte;
  logic       out_empty;
  logic       out_pop;
  logic [1:0] out_kind;
  logic       out_serial_bit;
  logic [7:0] out_delay_ms;
  logic       out_last;

  table_phase_t parse_phase;
  logic [7:0]   held_cmd;
  logic [7:0]   words_left;
  lcd_result_t  pending_results[$];
  lcd_result_t  want;

  int  errors;
  int  cycles;
  int  bytes_sent;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  hold_output;

  lcd_init_table_spi9_sequencer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_table_byte  (in_table_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_kind       (out_kind),
    .out_serial_bit (out_serial_bit),
    .out_delay_ms   (out_delay_ms),
    .out_last       (out_last)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  function automatic void queue_word(input logic flag, input logic [7:0] value);
    pending_results.push_back('{lits_pkg::KIND_BIT, flag, 8'd0, 1'b0});
    for (int i = 7; i >= 0; i--) begin
      pending_results.push_back('{lits_pkg::KIND_BIT, value[i], 8'd0, i == 0});
    end
  endfunction

  function automatic void predict_table_byte(input logic [7:0] b);
    case (parse_phase)
      ST_SECOND: begin
        if (b == lits_pkg::MARK_END) begin
          pending_results.push_back('{lits_pkg::KIND_END, 1'b0, 8'd0, 1'b1});
          parse_phase = ST_ENDED;
        end else if (b == lits_pkg::MARK_DELAY) begin
          parse_phase = ST_DELAY;
        end else begin
          queue_word(1'b0, held_cmd);
          if (b == 8'd0) begin
            parse_phase = ST_PAD;
          end else begin
            words_left  = b;
            parse_phase = ST_DATA;
          end
        end
      end
      ST_DELAY: begin
        pending_results.push_back('{lits_pkg::KIND_DELAY, 1'b0, b, 1'b1});
        parse_phase = ST_COMMAND;
      end
      ST_DATA: begin
        queue_word(1'b1, b);
        words_left = words_left - 8'd1;
        if (words_left == 8'd0) parse_phase = ST_COMMAND;
      end
      ST_PAD:   parse_phase = ST_COMMAND;
      ST_ENDED: ;
      default: begin
        held_cmd    = b;
        parse_phase = ST_SECOND;
      end
    endcase
  endfunction

  // Present one byte from a falling edge and hold it until the transfer.
  task automatic push_table_byte(input logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_push       = 1'b1;
    in_table_byte = b;
    do @(posedge clk); while (in_full);
    predict_table_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_data_record(input logic [7:0] cmd, input logic [7:0] len);
    push_table_byte(cmd);
    push_table_byte(len);
    if (len == 8'd0) begin
      push_table_byte(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < len; i++) push_table_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_delay_record(input logic [7:0] cmd, input logic [7:0] ms);
    push_table_byte(cmd);
    push_table_byte(lits_pkg::MARK_DELAY);
    push_table_byte(ms);
  endtask

  // Keep stray bytes from ending the table or opening a very long record.
  task automatic send_stray_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (parse_phase == ST_SECOND && b != lits_pkg::MARK_DELAY) b = {5'd0, b[2:0]};
    push_table_byte(b);
  endtask

  task automatic wait_drained();
    in_push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic test_directed();
    push_table_byte(8'h00);
    push_table_byte(8'h01);
    push_table_byte(8'h00);
    push_table_byte(8'hFF);
    push_table_byte(8'h02);
    push_table_byte(8'hFF);
    push_table_byte(8'hAA);
    push_table_byte(8'hA5);
    push_table_byte(8'h00);
    push_table_byte(lits_pkg::MARK_END);
    push_table_byte(8'h80);
    push_table_byte(8'h01);
    push_table_byte(lits_pkg::MARK_DELAY);
    send_delay_record(lits_pkg::MARK_DELAY, 8'h00);
    send_delay_record(8'h3C, 8'hFF);
    send_delay_record(8'h11, lits_pkg::MARK_DELAY);
    send_data_record(8'h55, 8'd0);
    wait_drained();
  endtask

  task automatic test_random_records();
    int target;
    int pick;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 11) == 0) tx_idle_on = !tx_idle_on;
      if ($urandom_range(0, 11) == 0) rx_idle_on = !rx_idle_on;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_data_record(8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)));
      end else if (pick < 8) begin
        send_delay_record(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_stray_byte();
        while (parse_phase != ST_COMMAND) send_stray_byte();
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_longest_record();
    send_data_record(8'($urandom_range(0, 255)), 8'd30);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    hold_output = 1'b1;
    repeat (6) send_data_record(8'($urandom_range(0, 255)), 8'd2);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (5) begin
      send_data_record(8'($urandom_range(0, 255)), 8'($urandom_range(1, 3)));
      send_delay_record(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    wait_drained();
  endtask

  task automatic test_table_end();
    push_table_byte(8'h29);
    push_table_byte(lits_pkg::MARK_END);
    push_table_byte(8'h2A);
    push_table_byte(8'h01);
    push_table_byte(lits_pkg::MARK_DELAY);
    push_table_byte(lits_pkg::MARK_END);
    push_table_byte(8'h00);
    repeat (4) push_table_byte(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  // Receiver: random pop bursts, plus one long hold on request.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_pop = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_output = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_pop = 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_pop = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: kind %0d bit %0d delay %0d last %0d",
               out_kind, out_serial_bit, out_delay_ms, out_last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_kind);
          errors++;
        end
        if (out_serial_bit !== want.serial_bit) begin
          $error("serial_bit: expected %0d, got %0d", want.serial_bit, out_serial_bit);
          errors++;
        end
        if (out_delay_ms !== want.delay_ms) begin
          $error("delay_ms: expected %0d, got %0d", want.delay_ms, out_delay_ms);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    cycles        = 0;
    bytes_sent    = 0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    hold_output   = 1'b0;
    parse_phase   = ST_COMMAND;
    held_cmd      = 8'd0;
    words_left    = 8'd0;
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_table_byte = 8'd0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_records();
    test_longest_record();
    test_output_backpressure();
    test_back_to_back();
    test_table_end();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
